/* hw/rtl/aea_pkg.sv */
package aea_pkg;

   // Fixed-point formats of the datapath.
   localparam int EV_FRAC_BITS = 8;
   localparam int EV_BITS      = 14;
   localparam int LUM_BITS     = 16;
   localparam int COMP_BITS    = 12;
   localparam int GAIN_BITS    = 17;
   localparam int REPORT_BITS  = 32;

   // Luminance samples beyond +/-20 EV are treated as bogus.
   localparam logic signed [LUM_BITS:0] LUM_LIMIT = (LUM_BITS + 1)'(20 << EV_FRAC_BITS);

   // Smoothing coefficients in Q0.16.
   localparam logic [13:0] COEF_UP   = 14'd5243;
   localparam logic [13:0] COEF_DOWN = 14'd9830;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(4096);
   localparam logic [GAIN_BITS-1:0] GAIN_MAX = GAIN_BITS'(131071);

   // Item kinds carried on tuser.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_RESET  = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_ENABLE     = 3'd0;
   localparam logic [2:0] REG_FIXED_MODE = 3'd1;
   localparam logic [2:0] REG_METER_MODE = 3'd2;
   localparam logic [2:0] REG_COMP_EV    = 3'd3;
   localparam logic [2:0] REG_MIN_EV     = 3'd4;
   localparam logic [2:0] REG_MAX_EV     = 3'd5;

   // 2^(k/16) and 2^(k/256) in Q16, indexed by the high and low nibble of the fraction.
   localparam logic [16:0] POW_HI [16] = '{
      17'd65536, 17'd68438, 17'd71468, 17'd74632, 17'd77936, 17'd81386, 17'd84990, 17'd88752,
      17'd92682, 17'd96785, 17'd101070, 17'd105545, 17'd110218, 17'd115098, 17'd120194,
      17'd125515
   };
   localparam logic [16:0] POW_LO [16] = '{
      17'd65536, 17'd65714, 17'd65892, 17'd66071, 17'd66250, 17'd66429, 17'd66609, 17'd66790,
      17'd66971, 17'd67153, 17'd67335, 17'd67517, 17'd67700, 17'd67884, 17'd68068, 17'd68252
   };

   // Per metering mode scale in Q12: average, center weighted, spot, histogram.
   localparam logic [12:0] MODE_FACTOR [4] = '{13'd4096, 13'd4424, 13'd4833, 13'd4096};

   typedef struct packed {
      logic                        enable;
      logic                        fixed_mode;
      logic [1:0]                  meter_mode;
      logic signed [COMP_BITS-1:0] comp_ev;
      logic signed [EV_BITS-1:0]   min_ev;
      logic signed [EV_BITS-1:0]   max_ev;
   } cfg_type;

   typedef struct packed {
      logic                       kind;
      logic signed [LUM_BITS-1:0] log_lum;
      logic                       lum_valid;
   } item_type;

endpackage

/* hw/rtl/aea_csr.sv */
module aea_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output aea_pkg::cfg_type cfg
);

   aea_pkg::cfg_type cfg_ff;
   aea_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            aea_pkg::REG_ENABLE:     cfg_in.enable     = csr_pwdata[0];
            aea_pkg::REG_FIXED_MODE: cfg_in.fixed_mode = csr_pwdata[0];
            aea_pkg::REG_METER_MODE: cfg_in.meter_mode = csr_pwdata[1:0];
            aea_pkg::REG_COMP_EV:    cfg_in.comp_ev    = csr_pwdata[aea_pkg::COMP_BITS-1:0];
            aea_pkg::REG_MIN_EV:     cfg_in.min_ev     = csr_pwdata[aea_pkg::EV_BITS-1:0];
            aea_pkg::REG_MAX_EV:     cfg_in.max_ev     = csr_pwdata[aea_pkg::EV_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= 1'b0;
         cfg_ff.fixed_mode <= 1'b0;
         cfg_ff.meter_mode <= 2'd1;
         cfg_ff.comp_ev    <= '0;
         cfg_ff.min_ev     <= aea_pkg::EV_BITS'(-1024);
         cfg_ff.max_ev     <= aea_pkg::EV_BITS'(1024);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         aea_pkg::REG_ENABLE:     csr_prdata = 32'(cfg_ff.enable);
         aea_pkg::REG_FIXED_MODE: csr_prdata = 32'(cfg_ff.fixed_mode);
         aea_pkg::REG_METER_MODE: csr_prdata = 32'(cfg_ff.meter_mode);
         aea_pkg::REG_COMP_EV:    csr_prdata = 32'(unsigned'(cfg_ff.comp_ev));
         aea_pkg::REG_MIN_EV:     csr_prdata = 32'(unsigned'(cfg_ff.min_ev));
         aea_pkg::REG_MAX_EV:     csr_prdata = 32'(unsigned'(cfg_ff.max_ev));
         default:                 csr_prdata = '0;
      endcase
   end

endmodule

/* hw/rtl/aea_gain.sv */
module aea_gain (
   input  logic                            clock,
   input  aea_pkg::cfg_type                cfg,
   input  logic                            load,
   output logic [aea_pkg::GAIN_BITS-1:0]   meter_gain
);

   logic [7:0]                      frac;
   logic [33:0]                     pow_prod;
   logic [16:0]                     mant_ff;
   logic [16:0]                     mant_in;
   logic [29:0]                     scaled;
   logic [3:0]                      ev_int;
   logic [4:0]                      shift_amt;
   logic [30:0]                     rounded;
   logic [30:0]                     shifted;
   logic [aea_pkg::GAIN_BITS-1:0]   gain_ff;
   logic [aea_pkg::GAIN_BITS-1:0]   gain_in;

   // The compensation is already Q8: low byte is the fraction, the rest the integer part.
   assign frac   = cfg.comp_ev[7:0];
   assign ev_int = cfg.comp_ev[aea_pkg::COMP_BITS-1:8];

   // The mantissa only follows the configuration, so it is computed ahead and registered.
   assign pow_prod = 34'(aea_pkg::POW_HI[frac[7:4]]) * 34'(aea_pkg::POW_LO[frac[3:0]]);
   assign mant_in  = 17'((pow_prod + 34'd32768) >> 16);

   always_ff @(posedge clock) begin
      mant_ff <= mant_in;
   end

   // Scale is Q28 after the multiply; shift by 16 minus the integer exponent, rounding half up.
   assign scaled    = 30'(aea_pkg::MODE_FACTOR[cfg.meter_mode]) * 30'(mant_ff);
   assign shift_amt = 5'd16 - 5'({ev_int[3], ev_int});
   assign rounded   = {1'b0, scaled} + (31'd1 << (shift_amt - 5'd1));
   assign shifted   = rounded >> shift_amt;

   always_comb begin
      if (!cfg.enable || cfg.fixed_mode) begin
         gain_in = aea_pkg::GAIN_ONE;
      end else if (shifted > 31'(aea_pkg::GAIN_MAX)) begin
         gain_in = aea_pkg::GAIN_MAX;
      end else begin
         gain_in = shifted[aea_pkg::GAIN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gain_ff <= gain_in;
      end
   end

   assign meter_gain = gain_ff;

endmodule

/* hw/rtl/aea_update.sv */
module aea_update #(
   parameter int COUNT_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  aea_pkg::cfg_type                      cfg,
   input  logic                                  fire,
   input  aea_pkg::item_type                     item,
   output logic signed [aea_pkg::EV_BITS-1:0]    current_ev,
   output logic signed [aea_pkg::EV_BITS-1:0]    target_ev,
   output logic                                  locked,
   output logic [aea_pkg::REPORT_BITS-1:0]       frame_count,
   output logic [aea_pkg::REPORT_BITS-1:0]       reset_count,
   output logic signed [aea_pkg::EV_BITS-1:0]    last_lum
);

   localparam int RptBits = (COUNT_BITS < aea_pkg::REPORT_BITS) ? COUNT_BITS
                                                               : aea_pkg::REPORT_BITS;

   logic signed [aea_pkg::EV_BITS-1:0] smooth_ff, smooth_in;
   logic signed [aea_pkg::EV_BITS-1:0] goal_ff, goal_in;
   logic signed [aea_pkg::EV_BITS-1:0] lum_ff, lum_in;
   logic                               lock_ff, lock_in;
   logic [COUNT_BITS-1:0]              frames_ff, frames_in;
   logic [COUNT_BITS-1:0]              resets_ff, resets_in;

   logic signed [aea_pkg::LUM_BITS:0]  lum_wide;
   logic signed [aea_pkg::LUM_BITS:0]  ev_raw;
   logic signed [aea_pkg::EV_BITS-1:0] ev_clamped;
   logic signed [aea_pkg::EV_BITS:0]   ev_diff;
   logic signed [29:0]                 step_prod;
   logic                               reject;

   assign lum_wide = (aea_pkg::LUM_BITS + 1)'(item.log_lum);
   assign ev_raw   = (aea_pkg::LUM_BITS + 1)'(cfg.comp_ev) - lum_wide;

   // With min above max, anything not below min lands on max.
   always_comb begin
      if (ev_raw < (aea_pkg::LUM_BITS + 1)'(cfg.min_ev)) begin
         ev_clamped = cfg.min_ev;
      end else if (ev_raw > (aea_pkg::LUM_BITS + 1)'(cfg.max_ev)) begin
         ev_clamped = cfg.max_ev;
      end else if (ev_raw < (aea_pkg::LUM_BITS + 1)'(cfg.max_ev)) begin
         ev_clamped = ev_raw[aea_pkg::EV_BITS-1:0];
      end else begin
         ev_clamped = cfg.max_ev;
      end
   end

   // Taking the upper bits of the product floors the Q16 step toward minus infinity.
   assign ev_diff   = (aea_pkg::EV_BITS + 1)'(ev_clamped) - (aea_pkg::EV_BITS + 1)'(smooth_ff);
   assign step_prod = 30'(ev_diff) * ((ev_clamped > smooth_ff) ? 30'(aea_pkg::COEF_UP)
                                                               : 30'(aea_pkg::COEF_DOWN));

   assign reject = !cfg.enable || cfg.fixed_mode || !item.lum_valid
                   || (lum_wide < -aea_pkg::LUM_LIMIT) || (lum_wide > aea_pkg::LUM_LIMIT);

   always_comb begin
      smooth_in = smooth_ff;
      goal_in   = goal_ff;
      lum_in    = lum_ff;
      lock_in   = lock_ff;
      frames_in = frames_ff;
      resets_in = resets_ff;
      if (fire) begin
         if (item.kind == aea_pkg::KIND_RESET) begin
            if (cfg.enable) begin
               smooth_in = '0;
               goal_in   = '0;
               lum_in    = '0;
               lock_in   = 1'b0;
               resets_in = resets_ff + COUNT_BITS'(1);
            end
         end else begin
            frames_in = frames_ff + COUNT_BITS'(1);
            if (reject) begin
               lock_in = 1'b0;
            end else begin
               lum_in  = item.log_lum[aea_pkg::EV_BITS-1:0];
               goal_in = ev_clamped;
               lock_in = 1'b1;
               if (!lock_ff) begin
                  smooth_in = ev_clamped;
               end else begin
                  smooth_in = smooth_ff + step_prod[16 +: aea_pkg::EV_BITS];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         goal_ff   <= '0;
         lum_ff    <= '0;
         lock_ff   <= 1'b0;
         frames_ff <= '0;
         resets_ff <= '0;
      end else begin
         smooth_ff <= smooth_in;
         goal_ff   <= goal_in;
         lum_ff    <= lum_in;
         lock_ff   <= lock_in;
         frames_ff <= frames_in;
         resets_ff <= resets_in;
      end
   end

   assign current_ev  = smooth_ff;
   assign target_ev   = goal_ff;
   assign locked      = lock_ff;
   assign last_lum    = lum_ff;
   assign frame_count = aea_pkg::REPORT_BITS'(frames_ff[RptBits-1:0]);
   assign reset_count = aea_pkg::REPORT_BITS'(resets_ff[RptBits-1:0]);

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind == aea_pkg::KIND_RESET && cfg.enable
      |=> !lock_ff && smooth_ff == '0 && goal_ff == '0 && lum_ff == '0)
      else $error("reset event did not clear the adaptation state");

   a_sample_counts: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind == aea_pkg::KIND_SAMPLE
      |=> frames_ff == $past(frames_ff) + COUNT_BITS'(1) && $stable(resets_ff))
      else $error("sample did not advance the frame count alone");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(smooth_ff) && $stable(goal_ff) && $stable(lock_ff)
                && $stable(frames_ff) && $stable(resets_ff))
      else $error("state changed without a processed item");

   a_reject_unlocks: assert property (@(posedge clock) disable iff (reset)
      fire && item.kind == aea_pkg::KIND_SAMPLE && reject |=> !lock_ff)
      else $error("rejected sample left the lock set");
`endif

endmodule

/* hw/rtl/auto_exposure_adaptation_core.sv */
// Auto-exposure eye adaptation controller, one item per frame.
// req channel: tuser is the item kind (0 luminance sample, 1 reset event);
// tdata carries log_lum (Q8, signed) and lum_valid. Every item gives exactly
// one transfer on the rsp channel with the smoothed and target EV, the lock
// flag, the meter gain (Q12), both counters and the last accepted luminance.
// From the req transfer to rsp_tvalid an item passes the input register and then
// the update logic into the state registers, which double as the result
// register. Throughput is one item per cycle while rsp_tready stays high; the
// limit is the single state update per clock that each item depends on.
// The meter gain mantissa is registered from the configuration, so it is
// ready in the cycle after a configuration register changes.
// While rsp_tready is low the result holds and one more item is taken into
// the input register; req_tready then drops until the result is taken.
// Reset clears the state, the counters and the configuration registers to their defaults.
// The user must write registers over the csr port only while no item is in flight; the block does not enforce it.
module auto_exposure_adaptation_core #(
   parameter int COUNT_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // log_lum[15:0], lum_valid[16], zero[23:17]
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // current_ev[13:0], target_ev[27:14], locked[28],
                                     // meter_gain[45:29], frame_count[77:46],
                                     // reset_count[109:78], last_lum[123:110], zero[127:124]
);

   aea_pkg::cfg_type  cfg;
   aea_pkg::item_type item_ff, item_in;
   logic              in_valid_ff, in_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   logic              fire;
   logic              req_xfer;

   logic signed [aea_pkg::EV_BITS-1:0]  current_ev, target_ev, last_lum;
   logic                                locked;
   logic [aea_pkg::GAIN_BITS-1:0]       meter_gain;
   logic [aea_pkg::REPORT_BITS-1:0]     frame_count, reset_count;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign item_in.kind      = req_tuser;
   assign item_in.log_lum   = req_tdata[15:0];
   assign item_in.lum_valid = req_tdata[16];

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= item_in;
      end
   end

   aea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   aea_gain u_gain (
      .clock      (clock),
      .cfg        (cfg),
      .load       (fire),
      .meter_gain (meter_gain)
   );

   aea_update #(
      .COUNT_BITS (COUNT_BITS)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .fire        (fire),
      .item        (item_ff),
      .current_ev  (current_ev),
      .target_ev   (target_ev),
      .locked      (locked),
      .frame_count (frame_count),
      .reset_count (reset_count),
      .last_lum    (last_lum)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, last_lum, reset_count, frame_count, meter_gain, locked,
                        target_ev, current_ev};

`ifndef SYNTHESIS
   a_fire_makes_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed item produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !fire)
      else $error("pending result overwritten");

   a_full_stalls_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted with both stages full");
`endif

endmodule

/* sim/auto_exposure_adaptation_core_tb.sv */
module auto_exposure_adaptation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0]                         pad;
      logic signed [aea_pkg::EV_BITS-1:0] last_lum;
      logic [31:0]                        reset_count;
      logic [31:0]                        frame_count;
      logic [aea_pkg::GAIN_BITS-1:0]      meter_gain;
      logic                               locked;
      logic signed [aea_pkg::EV_BITS-1:0] target_ev;
      logic signed [aea_pkg::EV_BITS-1:0] current_ev;
   } exposure_result_type;

   localparam int IDLE_LIMIT = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;   // log_lum[15:0], lum_valid[16], zero[23:17]
   logic         req_tuser = 1'b0; // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // current_ev, target_ev, locked, meter_gain,
                                   // frame_count, reset_count, last_lum, zero

   auto_exposure_adaptation_core DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the registers and of the adaptation state.
   aea_pkg::cfg_type cfg_shadow;
   int               ev_smooth;
   int               ev_goal;
   int               lum_kept;
   logic             is_locked;
   logic [31:0]      frames_total;
   logic [31:0]      resets_total;

   aea_pkg::item_type   pending_items[$];
   exposure_result_type exposure_due[$];
   aea_pkg::item_type   item_on_bus;
   exposure_result_type got_result;
   exposure_result_type want_result;

   int   items_queued = 0;
   int   items_taken = 0;
   int   results_seen = 0;
   int   reset_items = 0;
   int   settings_used = 0;
   int   error_count = 0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   idle_cycles = 0;
   logic req_idle_on = 1'b0;
   logic rsp_idle_on = 1'b0;

   task automatic report_error(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   function automatic logic [aea_pkg::GAIN_BITS-1:0] predicted_gain(
      input aea_pkg::cfg_type c);
      int                comp;
      int                whole;
      int                frac;
      int                shift;
      longint unsigned   hi;
      longint unsigned   lo;
      longint unsigned   mant;
      longint unsigned   scaled;
      if (!c.enable || c.fixed_mode) begin
         return aea_pkg::GAIN_ONE;
      end
      comp = c.comp_ev;
      whole = comp >>> 8;
      frac = comp & 255;
      hi = aea_pkg::POW_HI[frac >> 4];
      lo = aea_pkg::POW_LO[frac & 15];
      mant = (hi * lo + 64'd32768) >> 16;
      scaled = aea_pkg::MODE_FACTOR[c.meter_mode];
      scaled = scaled * mant;
      shift = 16 - whole;
      // The exponent's integer part is applied as a right shift rounding half up.
      scaled = (scaled + (64'd1 << (shift - 1))) >> shift;
      if (scaled > 64'(aea_pkg::GAIN_MAX)) begin
         return aea_pkg::GAIN_MAX;
      end
      return scaled[aea_pkg::GAIN_BITS-1:0];
   endfunction

   task automatic predict_exposure(input aea_pkg::item_type it);
      exposure_result_type r;
      int                  lum;
      int                  lim;
      int                  ev;
      int                  lo_clamp;
      int                  hi_clamp;
      int                  coef;
      longint              prod;
      lum = it.log_lum;
      lim = 20 << aea_pkg::EV_FRAC_BITS;
      if (it.kind == aea_pkg::KIND_RESET) begin
         if (cfg_shadow.enable) begin
            is_locked = 1'b0;
            lum_kept = 0;
            ev_smooth = 0;
            ev_goal = 0;
            resets_total++;
         end
      end else begin
         frames_total++;
         if (!cfg_shadow.enable || cfg_shadow.fixed_mode || !it.lum_valid ||
             lum < -lim || lum > lim) begin
            is_locked = 1'b0;
         end else begin
            lum_kept = lum;
            lo_clamp = cfg_shadow.min_ev;
            hi_clamp = cfg_shadow.max_ev;
            ev = -lum + int'(cfg_shadow.comp_ev);
            // With the clamps crossed, anything not below the minimum lands on the maximum.
            if (ev < lo_clamp) begin
               ev = lo_clamp;
            end else if (ev > hi_clamp) begin
               ev = hi_clamp;
            end
            ev_goal = ev;
            if (!is_locked) begin
               ev_smooth = ev;
               is_locked = 1'b1;
            end else begin
               coef = (ev > ev_smooth) ? int'(aea_pkg::COEF_UP) : int'(aea_pkg::COEF_DOWN);
               prod = longint'(ev - ev_smooth) * coef;
               ev_smooth = ev_smooth + int'(prod >>> 16);
            end
         end
      end
      r.pad = '0;
      r.current_ev = ev_smooth[aea_pkg::EV_BITS-1:0];
      r.target_ev = ev_goal[aea_pkg::EV_BITS-1:0];
      r.locked = is_locked;
      r.meter_gain = predicted_gain(cfg_shadow);
      r.frame_count = frames_total;
      r.reset_count = resets_total;
      r.last_lum = lum_kept[aea_pkg::EV_BITS-1:0];
      exposure_due.push_back(r);
   endtask

   // Driver for the item channel.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_exposure(item_on_bus);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               item_on_bus = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item_on_bus.kind;
               req_tdata <= {7'b0, item_on_bus.lum_valid, item_on_bus.log_lum};
               if (req_idle_on && $urandom_range(0, 4) == 0) begin
                  req_gap = $urandom_range(1, 10);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor for the result channel, with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_result = rsp_tdata;
            if (exposure_due.size() == 0) begin
               report_error($sformatf("result %0d arrived with no item outstanding: %h",
                                      results_seen, rsp_tdata));
            end else begin
               want_result = exposure_due.pop_front();
               if (got_result.current_ev !== want_result.current_ev)
                  report_error($sformatf("result %0d current_ev %0d, want %0d", results_seen,
                                         got_result.current_ev, want_result.current_ev));
               if (got_result.target_ev !== want_result.target_ev)
                  report_error($sformatf("result %0d target_ev %0d, want %0d", results_seen,
                                         got_result.target_ev, want_result.target_ev));
               if (got_result.locked !== want_result.locked)
                  report_error($sformatf("result %0d locked %0d, want %0d", results_seen,
                                         got_result.locked, want_result.locked));
               if (got_result.meter_gain !== want_result.meter_gain)
                  report_error($sformatf("result %0d meter_gain %0d, want %0d", results_seen,
                                         got_result.meter_gain, want_result.meter_gain));
               if (got_result.frame_count !== want_result.frame_count)
                  report_error($sformatf("result %0d frame_count %0d, want %0d", results_seen,
                                         got_result.frame_count, want_result.frame_count));
               if (got_result.reset_count !== want_result.reset_count)
                  report_error($sformatf("result %0d reset_count %0d, want %0d", results_seen,
                                         got_result.reset_count, want_result.reset_count));
               if (got_result.last_lum !== want_result.last_lum)
                  report_error($sformatf("result %0d last_lum %0d, want %0d", results_seen,
                                         got_result.last_lum, want_result.last_lum));
               if (got_result.pad !== want_result.pad)
                  report_error($sformatf("result %0d padding bits %b not zero", results_seen,
                                         got_result.pad));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 6) == 0) begin
               rsp_gap = $urandom_range(1, 10);
            end
         end
      end
   end

   // Ends the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         aea_pkg::REG_ENABLE:     cfg_shadow.enable = value[0];
         aea_pkg::REG_FIXED_MODE: cfg_shadow.fixed_mode = value[0];
         aea_pkg::REG_METER_MODE: cfg_shadow.meter_mode = value[1:0];
         aea_pkg::REG_COMP_EV:    cfg_shadow.comp_ev = value[aea_pkg::COMP_BITS-1:0];
         aea_pkg::REG_MIN_EV:     cfg_shadow.min_ev = value[aea_pkg::EV_BITS-1:0];
         aea_pkg::REG_MAX_EV:     cfg_shadow.max_ev = value[aea_pkg::EV_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic en, input logic fx, input logic [1:0] mode,
                             input int comp, input int lo_ev, input int hi_ev);
      csr_write(aea_pkg::REG_ENABLE, {31'b0, en});
      csr_write(aea_pkg::REG_FIXED_MODE, {31'b0, fx});
      csr_write(aea_pkg::REG_METER_MODE, {30'b0, mode});
      csr_write(aea_pkg::REG_COMP_EV, 32'(comp));
      csr_write(aea_pkg::REG_MIN_EV, 32'(lo_ev));
      csr_write(aea_pkg::REG_MAX_EV, 32'(hi_ev));
      settings_used++;
   endtask

   task automatic push_item(input logic kind, input int lum, input logic valid);
      aea_pkg::item_type it;
      it.kind = kind;
      it.log_lum = lum[aea_pkg::LUM_BITS-1:0];
      it.lum_valid = valid;
      pending_items.push_back(it);
      items_queued++;
      if (kind == aea_pkg::KIND_RESET) begin
         reset_items++;
      end
   endtask

   // Mostly well-formed samples near the useful range, with some noise.
   task automatic push_random_item();
      int pick;
      int lum;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         push_item(aea_pkg::KIND_RESET, int'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
         lum = int'($urandom_range(0, 10240)) - 5120;
         push_item(aea_pkg::KIND_SAMPLE, lum, $urandom_range(0, 19) != 0);
      end else if (pick < 88) begin
         lum = int'($urandom_range(5117, 5123));
         if ($urandom_range(0, 1) == 1) begin
            lum = -lum;
         end
         push_item(aea_pkg::KIND_SAMPLE, lum, 1'b1);
      end else begin
         push_item(aea_pkg::KIND_SAMPLE, int'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   task automatic set_random_config();
      int comp;
      int lo_ev;
      int hi_ev;
      case ($urandom_range(0, 5))
         0:       comp = -2048;
         1:       comp = 2047;
         2:       comp = 0;
         default: comp = int'($urandom_range(0, 2048)) - 1024;
      endcase
      case ($urandom_range(0, 5))
         0: begin
            lo_ev = -8192;
            hi_ev = 8191;
         end
         1: begin
            lo_ev = int'($urandom_range(0, 4096));
            hi_ev = -int'($urandom_range(0, 4096));
         end
         2: begin
            lo_ev = int'($urandom_range(0, 600)) - 300;
            hi_ev = lo_ev + int'($urandom_range(0, 256));
         end
         default: begin
            lo_ev = -int'($urandom_range(0, 4096));
            hi_ev = int'($urandom_range(0, 4096));
         end
      endcase
      set_config($urandom_range(0, 9) != 0, $urandom_range(0, 6) == 0,
                 2'($urandom_range(0, 3)), comp, lo_ev, hi_ev);
   endtask

   // Waits until every item has been taken and answered, then lets the pipeline settle.
   task automatic drain();
      while (items_taken != items_queued || exposure_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   initial begin
      cfg_shadow.enable = 1'b0;
      cfg_shadow.fixed_mode = 1'b0;
      cfg_shadow.meter_mode = 2'd1;
      cfg_shadow.comp_ev = '0;
      cfg_shadow.min_ev = -14'sd1024;
      cfg_shadow.max_ev = 14'sd1024;
      ev_smooth = 0;
      ev_goal = 0;
      lum_kept = 0;
      is_locked = 1'b0;
      frames_total = '0;
      resets_total = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the block is disabled: samples are rejected and resets ignored.
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      push_item(aea_pkg::KIND_SAMPLE, 256, 1'b1);
      push_item(aea_pkg::KIND_RESET, 0, 1'b0);
      drain();

      // Snap, smoothing both ways, range edges, invalid data and a reset.
      set_config(1'b1, 1'b0, 2'd1, 0, -1024, 1024);
      push_item(aea_pkg::KIND_SAMPLE, 0, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 768, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, -768, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 5120, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 5121, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, -5120, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, -5121, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 32767, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, -32768, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 100, 1'b0);
      push_item(aea_pkg::KIND_SAMPLE, 200, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 300, 1'b1);
      push_item(aea_pkg::KIND_RESET, -1, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, -300, 1'b1);
      drain();

      // Fixed exposure: samples rejected, gain at one, resets still performed.
      set_config(1'b1, 1'b1, 2'd2, 2047, -8192, 8191);
      push_item(aea_pkg::KIND_SAMPLE, 0, 1'b1);
      push_item(aea_pkg::KIND_RESET, 0, 1'b1);
      drain();

      // Crossed clamps and a saturated gain.
      set_config(1'b1, 1'b0, 2'd3, 2047, 4096, -4096);
      push_item(aea_pkg::KIND_SAMPLE, -5120, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 5000, 1'b1);
      drain();

      // Widest clamps with the lowest compensation.
      set_config(1'b1, 1'b0, 2'd0, -2048, -8192, 8191);
      push_item(aea_pkg::KIND_SAMPLE, -5120, 1'b1);
      push_item(aea_pkg::KIND_SAMPLE, 5120, 1'b1);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         set_random_config();
         req_idle_on = (phase < 9) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase < 9) && ($urandom_range(0, 3) != 0);
         repeat (75) push_random_item();
         drain();
      end

      repeat (8) @(posedge clock);
      $display("Checked %0d results from %0d items, %0d of them reset events,",
               results_seen, items_taken, reset_items);
      $display("across %0d register settings with random idling on both channels.",
               settings_used);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* auto_exposure_adaptation_core.f */
hw/rtl/aea_pkg.sv
hw/rtl/aea_csr.sv
hw/rtl/aea_gain.sv
hw/rtl/aea_update.sv
hw/rtl/auto_exposure_adaptation_core.sv
sim/auto_exposure_adaptation_core_tb.sv
